/* sv/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the Phong lighting shader pipeline.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int unsigned LogRounds = 16;
    localparam logic [30:0] SpecThreshold = 31'd2684354;
    localparam logic [29:0] Exp2C1 = 30'd747141773;
    localparam logic [29:0] Exp2C2 = 30'd242730077;
    localparam logic [29:0] Exp2C3 = 30'd83848499;
    localparam logic [15:0] ShineReset = 16'd256;

    typedef enum logic [1:0] {
        REG_AMBIENT  = 2'd0,
        REG_DIFFUSE  = 2'd1,
        REG_SPECULAR = 2'd2,
        REG_SHINE    = 2'd3
    } reg_index_t;

    // Side data that travels along the pipeline with each word.
    typedef struct packed {
        logic        lit;
        logic        spec;
        logic [18:0] dfac;
    } side_t;

endpackage

/* sv/phong_light_shade_top.sv */
// ----------------------------------------------------------------------------
// phong_light_shade_top
// Phong shader: ambient, two-sided diffuse and specular power per hit.
// ----------------------------------------------------------------------------
// Usage: each slave word is one surface hit (normal, light and mirror
// vectors in Q2.14, and a shadow flag in s_axis_tuser). Each master word is
// one RGB colour in Q2.14. Colours and the exponent are written over the
// cfg port while no hit is in flight; index 0 ambient, 1 diffuse, 2 specular,
// 3 exponent.
// From acceptance to the master word there is one stage for the dot products,
// sixteen log2 rounds, one multiply, four exp2 stages, and two colour stages.
// One hit is accepted every cycle unless the output word is held.
// The whole pipeline advances together; when m_axis_tready is low and the
// output word is held, every stage holds, so nothing is lost or repeated.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module phong_light_shade_top
    import pls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // normal_x,y,z, light_x,y,z, mirror_x,y,z (16 bits each, lowest first)
    input  logic [143:0] s_axis_tdata,
    // shadowed
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // red_out, green_out, blue_out
    output logic [47:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam int unsigned Lat = 24;

    logic [47:0] amb_reg, dif_reg, spc_reg;
    logic [15:0] shine_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_reg   <= '0;
            dif_reg   <= '0;
            spc_reg   <= '0;
            shine_reg <= ShineReset;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_AMBIENT:  amb_reg   <= cfg_data;
                REG_DIFFUSE:  dif_reg   <= cfg_data;
                REG_SPECULAR: spc_reg   <= cfg_data;
                REG_SHINE:    shine_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [Lat-1:0] vld_reg;
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[Lat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: dot products.
    logic signed [15:0] v [9];
    for (genvar g = 0; g < 9; g++) begin : g_unpack
        assign v[g] = s_axis_tdata[16*g +: 16];
    end

    logic signed [33:0] dn, dr;
    assign dn = 34'(v[0] * v[3]) + 34'(v[1] * v[4]) + 34'(v[2] * v[5]);
    assign dr = 34'(v[6] * v[3]) + 34'(v[7] * v[4]) + 34'(v[8] * v[5]);

    side_t side1_reg;
    logic [17:0] x_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg.lit  <= !s_axis_tuser;
            side1_reg.spec <= !s_axis_tuser && (dr > 34'(signed'({1'b0, SpecThreshold})));
            side1_reg.dfac <= 19'((dn < 0 ? -dn : dn) >> 14);
            x_reg          <= dr[31:14];
        end
    end

    // Power unit, 21 stages behind stage 1.
    logic [34:0] ks;
    pls_power u_power (
        .aclk   (aclk),
        .en     (en),
        .x_in   (x_reg),
        .shine  (shine_reg),
        .ks_out (ks)
    );

    localparam int unsigned PowLat = 21;
    side_t side_pipe [PowLat+1];
    assign side_pipe[0] = side1_reg;
    for (genvar g = 0; g < PowLat; g++) begin : g_side
        side_t s_reg;
        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg <= side_pipe[g];
            end
        end
        assign side_pipe[g+1] = s_reg;
    end

    // Colour stages: products, then sum and saturate.
    side_t sd;
    assign sd = side_pipe[PowLat];
    logic [20:0] dterm_reg [3];
    logic [36:0] sterm_reg [3];
    logic [15:0] aterm_reg [3];
    logic [47:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                aterm_reg[k] <= amb_reg[16*k +: 16];
                dterm_reg[k] <= sd.lit ? 21'((35'(dif_reg[16*k +: 16]) * 35'(sd.dfac)) >> 14)
                                       : 21'd0;
                sterm_reg[k] <= sd.spec ? 37'((51'(spc_reg[16*k +: 16]) * 51'(ks)) >> 14)
                                        : 37'd0;
            end
        end
    end

    logic [37:0] sum [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = 38'(aterm_reg[k]) + 38'(dterm_reg[k]) + 38'(sterm_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                out_reg[16*k +: 16] <= (sum[k] > 38'd65535) ? 16'hFFFF : sum[k][15:0];
            end
        end
    end

    assign m_axis_tdata = out_reg;

    // A word may only leave when the pipeline has held it or moved it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with stall");

endmodule

/* sv/pls_log2_round.sv */
// ----------------------------------------------------------------------------
// pls_log2_round
// One registered round of the squaring log2: one fraction bit per stage.
// ----------------------------------------------------------------------------
module pls_log2_round
    import pls_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] m_in,
    input  logic [15:0] frac_in,
    output logic [31:0] m_out,
    output logic [15:0] frac_out
);

    logic [63:0] sq;
    logic [33:0] sq_sh;
    logic [31:0] m_reg;
    logic [15:0] frac_reg;

    // Square the Q1.30 mantissa and renormalise below 2.0.
    always_comb begin
        sq    = 64'(m_in) * 64'(m_in);
        sq_sh = sq[63:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sq_sh >= 34'h080000000) begin
                m_reg    <= sq_sh[32:1];
                frac_reg <= {frac_in[14:0], 1'b1};
            end else begin
                m_reg    <= sq_sh[31:0];
                frac_reg <= {frac_in[14:0], 1'b0};
            end
        end
    end

    assign m_out    = m_reg;
    assign frac_out = frac_reg;

endmodule

/* sv/pls_power.sv */
// ----------------------------------------------------------------------------
// pls_power
// Pipelined power unit: x^e via log2 (squaring rounds), product, exp2.
// ----------------------------------------------------------------------------
module pls_power
    import pls_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [17:0] x_in,
    input  logic [15:0] shine,
    output logic [34:0] ks_out
);

    localparam int unsigned Depth = LogRounds;

    logic [4:0]  msb;
    logic [31:0] m0;
    logic [31:0] m_pipe [Depth+1];
    logic [15:0] f_pipe [Depth+1];
    logic [4:0]  e_pipe [Depth+1];

    // Leading one search on an 18-bit value.
    always_comb begin
        msb = 5'd0;
        for (int k = 0; k < 18; k++) begin
            if (x_in[k]) begin
                msb = 5'(k);
            end
        end
        m0 = 32'(({14'd0, x_in} << (5'd30 - msb)));
    end

    assign m_pipe[0] = m0;
    assign f_pipe[0] = 16'd0;
    assign e_pipe[0] = msb;

    for (genvar g = 0; g < Depth; g++) begin : g_round
        logic [4:0] e_reg;
        pls_log2_round u_round (
            .aclk     (aclk),
            .en       (en),
            .m_in     (m_pipe[g]),
            .frac_in  (f_pipe[g]),
            .m_out    (m_pipe[g+1]),
            .frac_out (f_pipe[g+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                e_reg <= e_pipe[g];
            end
        end
        assign e_pipe[g+1] = e_reg;
    end

    // Log value, signed Q.16, times exponent Q8.8.
    logic signed [21:0] lg;
    logic signed [38:0] p_reg;
    assign lg = 22'(signed'({1'b0, e_pipe[Depth]}) - 22'sd14) * 22'sd65536
                + signed'({6'd0, f_pipe[Depth]});

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= 39'(lg) * signed'({23'd0, shine});
        end
    end

    // Integer part is a floor; fraction is the top 16 of the 24 fraction bits.
    logic signed [14:0] ip1_reg, ip2_reg, ip3_reg;
    logic [15:0] f1_reg, f2_reg;
    logic [29:0] t1_reg, t2_reg;
    logic [30:0] t3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ip1_reg <= p_reg[38:24];
            f1_reg  <= p_reg[23:8];
            t1_reg  <= Exp2C2 + 30'((46'(Exp2C3) * 46'(p_reg[23:8])) >> 16);
            ip2_reg <= ip1_reg;
            f2_reg  <= f1_reg;
            t2_reg  <= Exp2C1 + 30'((46'(t1_reg) * 46'(f1_reg)) >> 16);
            ip3_reg <= ip2_reg;
            t3_reg  <= 31'h40000000 + 31'((46'(t2_reg) * 46'(f2_reg)) >> 16);
        end
    end

    // Scale by 2^i with saturation and underflow.
    logic [34:0] ks_reg;
    logic [61:0] up;
    always_comb begin
        up = 62'(t3_reg) << 5'(ip3_reg[4:0] - 5'd16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ip3_reg >= 15'sd20) begin
                ks_reg <= 35'h400000000;
            end else if (ip3_reg > 15'sd16) begin
                ks_reg <= 35'(up);
            end else if (ip3_reg <= -15'sd47) begin
                ks_reg <= 35'd0;
            end else begin
                ks_reg <= 35'(t3_reg >> 6'(15'sd16 - ip3_reg));
            end
        end
    end

    assign ks_out = ks_reg;

endmodule

/* tb/tb_phong_light_shade_top.sv */
// ----------------------------------------------------------------------------
// tb_phong_light_shade_top
// Self-checking testbench for the Phong shader pipeline. Surface hits go in
// under several colour and exponent settings, first a directed set and then
// random hits. A scoreboard predicts each RGB word and compares it with the
// output, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_phong_light_shade_top;
    import pls_pkg::*;

    // Scoreboard: the colour registers, a predictor of the shading and the
    // queue of colours still owed by the pipeline.
    class shade_sb;
        logic [47:0] ambient, diffuse, specular;
        logic [15:0] shine;
        logic [47:0] colour_q[$];
        int          errors, hits, lit_spec, shadowed, saturated, checked;

        function new();
            ambient  = '0;
            diffuse  = '0;
            specular = '0;
            shine    = ShineReset;
        endfunction

        function void set_reg(reg_index_t idx, logic [47:0] val);
            case (idx)
                REG_AMBIENT:  ambient  = val;
                REG_DIFFUSE:  diffuse  = val;
                REG_SPECULAR: specular = val;
                REG_SHINE:    shine    = val[15:0];
                default: ;
            endcase
        endfunction

        // Base-2 logarithm of a Q14 value, signed Q.16, by repeated squaring.
        function longint log2_q16(longint x);
            int           msb;
            logic [63:0]  m;
            longint       frac;
            msb  = 0;
            frac = 0;
            for (int k = 0; k < 18; k++)
                if (x[k]) msb = k;
            m = 64'(x) << (30 - msb);
            for (int k = 0; k < LogRounds; k++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return longint'(msb - 14) * 65536 + frac;
        endfunction

        // Two to the power of a Q.24 value, as Q14, held at 2^34.
        function longint exp2_q14(longint p);
            longint      ip;
            logic [63:0] f, t;
            if (p >= 0) ip = p >>> 24;
            else ip = -((-p + 64'hFFFFFF) >> 24);
            if (ip >= 20) return longint'(1) << 34;
            f = 64'(p - ip * 16777216) >> 8;
            t = 64'(Exp2C3);
            t = 64'(Exp2C2) + ((t * f) >> 16);
            t = 64'(Exp2C1) + ((t * f) >> 16);
            t = (64'd1 << 30) + ((t * f) >> 16);
            if (ip > 16) return t << (ip - 16);
            if (16 - ip >= 63) return 0;
            return t >> (16 - ip);
        endfunction

        // Work out the colour for one accepted hit.
        function void note_hit(logic [143:0] vec, logic shadow);
            longint      dn, dr, dfac, ks, s;
            logic        lit, spec;
            logic [47:0] colour;
            dn = 0;
            dr = 0;
            for (int k = 0; k < 3; k++) begin
                dn += longint'(signed'(vec[16*k +: 16])) *
                      longint'(signed'(vec[16*(3+k) +: 16]));
                dr += longint'(signed'(vec[16*(6+k) +: 16])) *
                      longint'(signed'(vec[16*(3+k) +: 16]));
            end
            lit  = !shadow;
            spec = lit && (dr > longint'(SpecThreshold));
            dfac = lit ? ((dn < 0 ? -dn : dn) >> 14) : 0;
            ks   = spec ? exp2_q14(log2_q16(dr >> 14) * longint'(shine)) : 0;
            for (int k = 0; k < 3; k++) begin
                s = longint'(ambient[16*k +: 16]);
                if (lit) s += (longint'(diffuse[16*k +: 16]) * dfac) >> 14;
                if (spec) s += (longint'(specular[16*k +: 16]) * ks) >> 14;
                if (s > 65535) begin
                    s = 65535;
                    saturated++;
                end
                colour[16*k +: 16] = s[15:0];
            end
            hits++;
            if (spec) lit_spec++;
            if (shadow) shadowed++;
            colour_q.push_back(colour);
        endfunction

        // Compare one output word with the oldest owed colour.
        function void check_colour(logic [47:0] got);
            logic [47:0] want;
            string       names[3];
            names = '{"red_out", "green_out", "blue_out"};
            if (colour_q.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, got);
                errors++;
                return;
            end
            want = colour_q.pop_front();
            checked++;
            for (int k = 0; k < 3; k++)
                if (got[16*k +: 16] !== want[16*k +: 16]) begin
                    $display("%0t: %s expected %h actual %h", $time, names[k],
                             want[16*k +: 16], got[16*k +: 16]);
                    errors++;
                end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;

    shade_sb sb;
    int      tx_idle_pct, rx_idle_pct;
    int      rx_hold_left;
    int      quiet_cycles;

    phong_light_shade_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver: random back-pressure, or a long hold when one is requested.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: note accepted hits and check accepted colours.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_hit(s_axis_tdata, s_axis_tuser);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_colour(m_axis_tdata);
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 3000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one hit, with random idle cycles first, and wait for acceptance.
    task automatic send_hit(input logic [143:0] vec, input logic shadow);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vec;
        s_axis_tuser  <= shadow;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_vectors(input logic signed [15:0] n[3],
                                input logic signed [15:0] l[3],
                                input logic signed [15:0] r[3],
                                input logic shadow);
        send_hit({r[2], r[1], r[0], l[2], l[1], l[0], n[2], n[1], n[0]}, shadow);
    endtask

    // Drop the input valid and wait until the pipeline has drained.
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.colour_q.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [47:0] amb, input logic [47:0] dif,
                             input logic [47:0] spc, input logic [15:0] shn);
        write_reg(REG_AMBIENT, amb);
        write_reg(REG_DIFFUSE, dif);
        write_reg(REG_SPECULAR, spc);
        write_reg(REG_SHINE, {32'd0, shn});
    endtask

    function automatic logic [47:0] rand_colour();
        case ($urandom_range(3))
            0: return {3{16'($urandom_range(16384, 0))}};
            1: return {16'($urandom), 16'($urandom), 16'($urandom)};
            default: return {16'($urandom_range(16384)), 16'($urandom_range(16384)),
                             16'($urandom_range(16384))};
        endcase
    endfunction

    // One random hit: mostly moderate vectors, some with a mirror close to the
    // light so that highlights occur, the rest full-range noise.
    task automatic send_random_hit();
        logic signed [15:0] n[3], l[3], r[3];
        int                 sel;
        sel = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            if (sel < 7) begin
                n[k] = 16'($urandom_range(18000)) - 16'sd9000;
                l[k] = 16'($urandom_range(18000)) - 16'sd9000;
                r[k] = (sel < 4) ? l[k] + 16'($urandom_range(2000)) - 16'sd1000
                                 : 16'($urandom_range(18000)) - 16'sd9000;
            end else begin
                n[k] = 16'($urandom);
                l[k] = 16'($urandom);
                r[k] = 16'($urandom);
            end
        end
        send_vectors(n, l, r, $urandom_range(7) == 0);
    endtask

    // Directed hits: extremes, sign cases, the highlight threshold, and the
    // huge and tiny power cases.
    task automatic send_directed();
        logic signed [15:0] z[3], one_x[3], pmax[3], nmax[3], mix[3];
        logic signed [15:0] r_hi[3], r_lo[3], r_min[3], neg_x[3];
        z     = '{16'sd0, 16'sd0, 16'sd0};
        one_x = '{16'sd16384, 16'sd0, 16'sd0};
        neg_x = '{-16'sd16384, 16'sd0, 16'sd0};
        pmax  = '{16'sd32767, 16'sd32767, 16'sd32767};
        nmax  = '{-16'sd32768, -16'sd32768, -16'sd32768};
        mix   = '{16'sd32767, -16'sd32768, 16'sd1};
        r_hi  = '{16'sd164, 16'sd0, 16'sd0};
        r_lo  = '{16'sd163, 16'sd0, 16'sd0};
        r_min = '{16'sd1, 16'sd0, 16'sd0};
        send_vectors(z, z, z, 1'b0);
        send_vectors(one_x, one_x, one_x, 1'b0);
        send_vectors(neg_x, one_x, one_x, 1'b0);
        send_vectors(one_x, one_x, one_x, 1'b1);
        send_vectors(pmax, pmax, pmax, 1'b0);
        send_vectors(nmax, nmax, nmax, 1'b0);
        send_vectors(pmax, nmax, nmax, 1'b0);
        send_vectors(mix, mix, mix, 1'b0);
        send_vectors(mix, pmax, nmax, 1'b1);
        send_vectors(one_x, one_x, r_hi, 1'b0);
        send_vectors(one_x, one_x, r_lo, 1'b0);
        send_vectors(one_x, one_x, r_min, 1'b0);
        send_vectors(one_x, one_x, neg_x, 1'b0);
        send_vectors(nmax, pmax, pmax, 1'b0);
    endtask

    initial begin
        logic [15:0] shine_set[5];
        sb             = new();
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_AMBIENT;
        cfg_data       = '0;
        tx_idle_pct    = 26;
        rx_idle_pct    = 54;
        rx_hold_left   = 0;
        quiet_cycles   = 0;
        shine_set      = '{16'd256, 16'd65535, 16'd0, 16'd512, 16'd8000};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed hits under reset values, then under extreme settings.
        send_directed();
        drain();
        write_all('1, '1, '1, 16'hFFFF);
        send_directed();
        drain();
        write_all('0, 48'h4000_4000_4000, 48'h4000_2000_1000, 16'd0);
        send_directed();
        drain();

        // Random phases, each under its own settings and idling mix.
        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 54 : 0;
            rx_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 26 : 0;
            write_all(rand_colour(), rand_colour(), rand_colour(),
                      (ph == 4) ? 16'($urandom_range(100, 3000)) : shine_set[ph]);
            for (int i = 0; i < 172; i++) begin
                if (ph == 1 && i == 40)
                    rx_hold_left = 200;
                if (ph == 3 && i == 80) begin
                    // Stop offering words until every owed colour is out.
                    @(negedge aclk);
                    s_axis_tvalid <= 1'b0;
                    while (sb.colour_q.size() > 0) @(posedge aclk);
                end
                send_random_hit();
            end
            drain();
        end

        $display("Shaded %0d hits (%0d with highlight, %0d shadowed, %0d channels saturated),",
                 sb.hits, sb.lit_spec, sb.shadowed, sb.saturated);
        $display("checked %0d colour words across eight register settings.", sb.checked);
        if (sb.errors == 0 && sb.colour_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/pls_pkg.sv
sv/pls_log2_round.sv
sv/pls_power.sv
sv/phong_light_shade_top.sv
tb/tb_phong_light_shade_top.sv
